// ===== rtl/seg_isect_pkg.sv =====
// ----------------------------------------------------------------------------
// seg_isect_pkg
// Shared types for the segment intersection pipeline: orientation codes and
// the bounding box flags that travel alongside the cross products.
// ----------------------------------------------------------------------------
package seg_isect_pkg;

	typedef enum logic [1:0] {
		TURN_COLLINEAR,
		TURN_CW,
		TURN_CCW
	} turn_t;

	typedef struct packed {
		logic b_start_on_a;
		logic b_end_on_a;
		logic a_start_on_b;
		logic a_end_on_b;
	} box_hits_t;

endpackage

// ===== rtl/seg_isect_diff.sv =====
// ----------------------------------------------------------------------------
// seg_isect_diff
// First pipeline stage: direction vectors of both segments, endpoint offsets
// for the four orientation tests and the bounding box compares.
// ----------------------------------------------------------------------------
module seg_isect_diff #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  logic                          valid,
	input  logic signed [COORD_WIDTH-1:0] seg_a_start_x,
	input  logic signed [COORD_WIDTH-1:0] seg_a_start_y,
	input  logic signed [COORD_WIDTH-1:0] seg_a_end_x,
	input  logic signed [COORD_WIDTH-1:0] seg_a_end_y,
	input  logic signed [COORD_WIDTH-1:0] seg_b_start_x,
	input  logic signed [COORD_WIDTH-1:0] seg_b_start_y,
	input  logic signed [COORD_WIDTH-1:0] seg_b_end_x,
	input  logic signed [COORD_WIDTH-1:0] seg_b_end_y,
	output logic                          valid_s1,
	output logic signed [COORD_WIDTH:0]   dir_s1 [4],
	output logic signed [COORD_WIDTH:0]   ofs_x_s1 [4],
	output logic signed [COORD_WIDTH:0]   ofs_y_s1 [4],
	output seg_isect_pkg::box_hits_t      box_s1
);
	import seg_isect_pkg::*;

	localparam int DW = COORD_WIDTH + 1;

	logic signed [DW-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
	logic signed [DW-1:0] dir [4];
	logic signed [DW-1:0] ofs_x [4];
	logic signed [DW-1:0] ofs_y [4];
	box_hits_t            box;

	// m lies between e0 and e1, either order
	function automatic logic in_span(
		input logic signed [COORD_WIDTH-1:0] m,
		input logic signed [COORD_WIDTH-1:0] e0,
		input logic signed [COORD_WIDTH-1:0] e1
	);
		return (m >= e0 || m >= e1) && (m <= e0 || m <= e1);
	endfunction

	assign ax0 = DW'(seg_a_start_x);
	assign ay0 = DW'(seg_a_start_y);
	assign ax1 = DW'(seg_a_end_x);
	assign ay1 = DW'(seg_a_end_y);
	assign bx0 = DW'(seg_b_start_x);
	assign by0 = DW'(seg_b_start_y);
	assign bx1 = DW'(seg_b_end_x);
	assign by1 = DW'(seg_b_end_y);

	always_comb begin
		dir[0]   = ax1 - ax0;
		dir[1]   = ay1 - ay0;
		dir[2]   = bx1 - bx0;
		dir[3]   = by1 - by0;
		ofs_x[0] = bx0 - ax1;
		ofs_y[0] = by0 - ay1;
		ofs_x[1] = bx1 - ax1;
		ofs_y[1] = by1 - ay1;
		ofs_x[2] = ax0 - bx1;
		ofs_y[2] = ay0 - by1;
		ofs_x[3] = ax1 - bx1;
		ofs_y[3] = ay1 - by1;
	end

	always_comb begin
		box.b_start_on_a = in_span(seg_b_start_x, seg_a_start_x, seg_a_end_x) &&
			in_span(seg_b_start_y, seg_a_start_y, seg_a_end_y);
		box.b_end_on_a   = in_span(seg_b_end_x, seg_a_start_x, seg_a_end_x) &&
			in_span(seg_b_end_y, seg_a_start_y, seg_a_end_y);
		box.a_start_on_b = in_span(seg_a_start_x, seg_b_start_x, seg_b_end_x) &&
			in_span(seg_a_start_y, seg_b_start_y, seg_b_end_y);
		box.a_end_on_b   = in_span(seg_a_end_x, seg_b_start_x, seg_b_end_x) &&
			in_span(seg_a_end_y, seg_b_start_y, seg_b_end_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dir_s1   <= dir;
			ofs_x_s1 <= ofs_x;
			ofs_y_s1 <= ofs_y;
			box_s1   <= box;
		end
	end

endmodule

// ===== rtl/seg_isect_mul.sv =====
// ----------------------------------------------------------------------------
// seg_isect_mul
// Second pipeline stage: the two partial products of each of the four
// cross products, held at full width.
// ----------------------------------------------------------------------------
module seg_isect_mul #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              load,
	input  logic                              valid_s1,
	input  logic signed [COORD_WIDTH:0]       dir_s1 [4],
	input  logic signed [COORD_WIDTH:0]       ofs_x_s1 [4],
	input  logic signed [COORD_WIDTH:0]       ofs_y_s1 [4],
	input  seg_isect_pkg::box_hits_t          box_s1,
	output logic                              valid_s2,
	output logic signed [2*COORD_WIDTH+1:0]   prod_p_s2 [4],
	output logic signed [2*COORD_WIDTH+1:0]   prod_q_s2 [4],
	output seg_isect_pkg::box_hits_t          box_s2
);
	import seg_isect_pkg::*;

	localparam int PW = 2 * COORD_WIDTH + 2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			box_s2 <= box_s1;
		end
	end

	// turns about segment a use its direction, the others segment b
	for (genvar k = 0; k < 4; k++) begin : g_mul
		localparam int DX = (k < 2) ? 0 : 2;
		localparam int DY = DX + 1;

		always_ff @(posedge clk) begin
			if (load) begin
				prod_p_s2[k] <= PW'(dir_s1[DY]) * PW'(ofs_x_s1[k]);
				prod_q_s2[k] <= PW'(dir_s1[DX]) * PW'(ofs_y_s1[k]);
			end
		end
	end

endmodule

// ===== rtl/seg_isect_orient.sv =====
// ----------------------------------------------------------------------------
// seg_isect_orient
// Third pipeline stage: forms the four cross products and reduces each to
// an orientation code.
// ----------------------------------------------------------------------------
module seg_isect_orient #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             load,
	input  logic                             valid_s2,
	input  logic signed [2*COORD_WIDTH+1:0]  prod_p_s2 [4],
	input  logic signed [2*COORD_WIDTH+1:0]  prod_q_s2 [4],
	input  seg_isect_pkg::box_hits_t         box_s2,
	output logic                             valid_s3,
	output seg_isect_pkg::turn_t             turn_s3 [4],
	output seg_isect_pkg::box_hits_t         box_s3
);
	import seg_isect_pkg::*;

	localparam int CW = 2 * COORD_WIDTH + 3;

	logic signed [CW-1:0] xprod [4];
	turn_t                turn [4];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			xprod[k] = CW'(prod_p_s2[k]) - CW'(prod_q_s2[k]);
			if (xprod[k] == '0) begin
				turn[k] = TURN_COLLINEAR;
			end else if (xprod[k][CW-1]) begin
				turn[k] = TURN_CCW;
			end else begin
				turn[k] = TURN_CW;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (load) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			turn_s3 <= turn;
			box_s3  <= box_s2;
		end
	end

endmodule

// ===== rtl/segment_intersection_test.sv =====
// ----------------------------------------------------------------------------
// segment_intersection_test
// Decides whether two closed integer line segments touch or cross, using
// four exact orientation tests plus bounding box checks for collinear cases.
// ----------------------------------------------------------------------------
// Usage:
//   pair channel (pair_valid / pair_stall) carries the eight endpoint
//   coordinates of segments a and b; a transfer happens at a clock edge with
//   pair_valid high and pair_stall low
//   result channel (result_valid / result_stall) carries segments_intersect,
//   one result per accepted pair, in order
//   registers in order: differences and box compares, products,
//   cross product signs, then the result register
//   throughput is one pair per cycle while result_stall is low; each stage has its own valid bit and
//   moves whenever the stage after it is empty or moving, so bubbles are
//   squeezed out
//   when result_stall is high the result register holds, the stages fill up
//   behind it and pair_stall rises once every stage holds a pair; nothing is
//   dropped or repeated
//   reset clears all valid bits; no other state is kept
// ----------------------------------------------------------------------------
module segment_intersection_test #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pair_valid,
	output logic                          pair_stall,
	input  logic signed [COORD_WIDTH-1:0] seg_a_start_x,
	input  logic signed [COORD_WIDTH-1:0] seg_a_start_y,
	input  logic signed [COORD_WIDTH-1:0] seg_a_end_x,
	input  logic signed [COORD_WIDTH-1:0] seg_a_end_y,
	input  logic signed [COORD_WIDTH-1:0] seg_b_start_x,
	input  logic signed [COORD_WIDTH-1:0] seg_b_start_y,
	input  logic signed [COORD_WIDTH-1:0] seg_b_end_x,
	input  logic signed [COORD_WIDTH-1:0] seg_b_end_y,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic                          segments_intersect
);
	import seg_isect_pkg::*;

	logic                            valid_s1, valid_s2, valid_s3;
	logic                            load_s1, load_s2, load_s3, load_out;
	logic signed [COORD_WIDTH:0]     dir_s1 [4];
	logic signed [COORD_WIDTH:0]     ofs_x_s1 [4];
	logic signed [COORD_WIDTH:0]     ofs_y_s1 [4];
	logic signed [2*COORD_WIDTH+1:0] prod_p_s2 [4];
	logic signed [2*COORD_WIDTH+1:0] prod_q_s2 [4];
	box_hits_t                       box_s1, box_s2, box_s3;
	turn_t                           turn_s3 [4];
	logic                            crossing, touching;
	logic                            valid_q, hit_q;

	// a stage loads when it is empty or its contents move on
	assign load_out   = !valid_q || !result_stall;
	assign load_s3    = !valid_s3 || load_out;
	assign load_s2    = !valid_s2 || load_s3;
	assign load_s1    = !valid_s1 || load_s2;
	assign pair_stall = !load_s1;

	seg_isect_diff #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_diff (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (load_s1),
		.valid         (pair_valid),
		.seg_a_start_x (seg_a_start_x),
		.seg_a_start_y (seg_a_start_y),
		.seg_a_end_x   (seg_a_end_x),
		.seg_a_end_y   (seg_a_end_y),
		.seg_b_start_x (seg_b_start_x),
		.seg_b_start_y (seg_b_start_y),
		.seg_b_end_x   (seg_b_end_x),
		.seg_b_end_y   (seg_b_end_y),
		.valid_s1      (valid_s1),
		.dir_s1        (dir_s1),
		.ofs_x_s1      (ofs_x_s1),
		.ofs_y_s1      (ofs_y_s1),
		.box_s1        (box_s1)
	);

	seg_isect_mul #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_mul (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load_s2),
		.valid_s1  (valid_s1),
		.dir_s1    (dir_s1),
		.ofs_x_s1  (ofs_x_s1),
		.ofs_y_s1  (ofs_y_s1),
		.box_s1    (box_s1),
		.valid_s2  (valid_s2),
		.prod_p_s2 (prod_p_s2),
		.prod_q_s2 (prod_q_s2),
		.box_s2    (box_s2)
	);

	seg_isect_orient #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_orient (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load_s3),
		.valid_s2  (valid_s2),
		.prod_p_s2 (prod_p_s2),
		.prod_q_s2 (prod_q_s2),
		.box_s2    (box_s2),
		.valid_s3  (valid_s3),
		.turn_s3   (turn_s3),
		.box_s3    (box_s3)
	);

	// proper crossing, or an endpoint collinear with and inside the other segment
	always_comb begin
		crossing = (turn_s3[0] != turn_s3[1]) && (turn_s3[2] != turn_s3[3]);
		touching = (turn_s3[0] == TURN_COLLINEAR && box_s3.b_start_on_a) ||
			(turn_s3[1] == TURN_COLLINEAR && box_s3.b_end_on_a) ||
			(turn_s3[2] == TURN_COLLINEAR && box_s3.a_start_on_b) ||
			(turn_s3[3] == TURN_COLLINEAR && box_s3.a_end_on_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load_out) begin
			valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			hit_q <= crossing || touching;
		end
	end

	assign result_valid       = valid_q;
	assign segments_intersect = hit_q;

endmodule

// ===== rtl/seg_isect_chk.sv =====
// ----------------------------------------------------------------------------
// seg_isect_chk
// Port-level checks for the segment intersection block: reset, fixed
// latency with an open result channel, hold under stall, shared endpoint.
// ----------------------------------------------------------------------------
module seg_isect_chk #(
	parameter int COORD_WIDTH = 16
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          pair_valid,
	input logic                          pair_stall,
	input logic signed [COORD_WIDTH-1:0] seg_a_start_x,
	input logic signed [COORD_WIDTH-1:0] seg_a_start_y,
	input logic signed [COORD_WIDTH-1:0] seg_b_start_x,
	input logic signed [COORD_WIDTH-1:0] seg_b_start_y,
	input logic                          result_valid,
	input logic                          result_stall,
	input logic                          segments_intersect
);
	logic pair_xfer;
	logic shared_start;

	assign pair_xfer    = pair_valid && !pair_stall;
	assign shared_start = seg_a_start_x == seg_b_start_x &&
		seg_a_start_y == seg_b_start_y;

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !result_valid)
		else $error("result valid during reset");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		pair_xfer ##1 !result_stall ##1 !result_stall ##1 !result_stall
		|=> result_valid)
		else $error("result missing four cycles after transfer");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall
		|=> result_valid && $stable(segments_intersect))
		else $error("stalled result changed");

	a_shared_point: assert property (@(posedge clk) disable iff (!arst_n)
		pair_xfer && shared_start ##1 !result_stall ##1 !result_stall
		##1 !result_stall |=> result_valid && segments_intersect)
		else $error("shared start point not reported as hit");

endmodule

bind segment_intersection_test seg_isect_chk #(
	.COORD_WIDTH(COORD_WIDTH)
) u_chk (
	.clk                (clk),
	.arst_n             (arst_n),
	.pair_valid         (pair_valid),
	.pair_stall         (pair_stall),
	.seg_a_start_x      (seg_a_start_x),
	.seg_a_start_y      (seg_a_start_y),
	.seg_b_start_x      (seg_b_start_x),
	.seg_b_start_y      (seg_b_start_y),
	.result_valid       (result_valid),
	.result_stall       (result_stall),
	.segments_intersect (segments_intersect)
);

// ===== dv/tb_segment_intersection_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_segment_intersection_test
// Streams segment pairs through segment_intersection_test and compares every
// result in order with an exact orientation-based prediction of the touch or
// cross decision. Covers field extremes, collinear, degenerate and shared
// endpoint layouts, random pairs under several idle and stall mixes, a long
// output hold-off that backs the pipeline up, and drain pauses.
// ----------------------------------------------------------------------------
module tb_segment_intersection_test;
	import seg_isect_pkg::*;

	localparam int COORD_W     = 16;
	localparam int CLK_PERIOD  = 10;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 120;
	localparam int TAIL_CYCLES = 8;

	typedef struct packed {
		logic signed [COORD_W-1:0] a_sx;
		logic signed [COORD_W-1:0] a_sy;
		logic signed [COORD_W-1:0] a_ex;
		logic signed [COORD_W-1:0] a_ey;
		logic signed [COORD_W-1:0] b_sx;
		logic signed [COORD_W-1:0] b_sy;
		logic signed [COORD_W-1:0] b_ex;
		logic signed [COORD_W-1:0] b_ey;
	} seg_pair_t;

	logic clk = 1'b0;
	logic arst_n;
	logic pair_valid;
	logic pair_stall;
	logic signed [COORD_W-1:0] seg_a_start_x;
	logic signed [COORD_W-1:0] seg_a_start_y;
	logic signed [COORD_W-1:0] seg_a_end_x;
	logic signed [COORD_W-1:0] seg_a_end_y;
	logic signed [COORD_W-1:0] seg_b_start_x;
	logic signed [COORD_W-1:0] seg_b_start_y;
	logic signed [COORD_W-1:0] seg_b_end_x;
	logic signed [COORD_W-1:0] seg_b_end_y;
	logic result_valid;
	logic result_stall;
	logic segments_intersect;

	int   recv_stall_pct;
	logic hold_token;
	int   cycle_count = 0;
	int   pairs_sent = 0;

	segment_intersection_test #(
		.COORD_WIDTH(COORD_W)
	) u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.pair_valid        (pair_valid),
		.pair_stall        (pair_stall),
		.seg_a_start_x     (seg_a_start_x),
		.seg_a_start_y     (seg_a_start_y),
		.seg_a_end_x       (seg_a_end_x),
		.seg_a_end_y       (seg_a_end_y),
		.seg_b_start_x     (seg_b_start_x),
		.seg_b_start_y     (seg_b_start_y),
		.seg_b_end_x       (seg_b_end_x),
		.seg_b_end_y       (seg_b_end_y),
		.result_valid      (result_valid),
		.result_stall      (result_stall),
		.segments_intersect(segments_intersect)
	);

	function automatic turn_t turn_of_points(longint ax, longint ay, longint bx, longint by,
		longint cx, longint cy);
		longint cprod;
		cprod = (by - ay) * (cx - bx) - (bx - ax) * (cy - by);
		if (cprod == 0) begin
			return TURN_COLLINEAR;
		end
		return (cprod > 0) ? TURN_CW : TURN_CCW;
	endfunction

	// m within the bounding box spanned by a and b
	function automatic bit in_bbox(longint ax, longint ay, longint mx, longint my,
		longint bx, longint by);
		longint lox, hix, loy, hiy;
		lox = (ax < bx) ? ax : bx;
		hix = (ax < bx) ? bx : ax;
		loy = (ay < by) ? ay : by;
		hiy = (ay < by) ? by : ay;
		return (mx >= lox) && (mx <= hix) && (my >= loy) && (my <= hiy);
	endfunction

	function automatic bit predict_touch(seg_pair_t p);
		longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
		turn_t t1, t2, t3, t4;
		ax0 = $signed(p.a_sx);
		ay0 = $signed(p.a_sy);
		ax1 = $signed(p.a_ex);
		ay1 = $signed(p.a_ey);
		bx0 = $signed(p.b_sx);
		by0 = $signed(p.b_sy);
		bx1 = $signed(p.b_ex);
		by1 = $signed(p.b_ey);
		t1 = turn_of_points(ax0, ay0, ax1, ay1, bx0, by0);
		t2 = turn_of_points(ax0, ay0, ax1, ay1, bx1, by1);
		t3 = turn_of_points(bx0, by0, bx1, by1, ax0, ay0);
		t4 = turn_of_points(bx0, by0, bx1, by1, ax1, ay1);
		if (t1 != t2 && t3 != t4) begin
			return 1'b1;
		end
		if (t1 == TURN_COLLINEAR && in_bbox(ax0, ay0, bx0, by0, ax1, ay1)) begin
			return 1'b1;
		end
		if (t2 == TURN_COLLINEAR && in_bbox(ax0, ay0, bx1, by1, ax1, ay1)) begin
			return 1'b1;
		end
		if (t3 == TURN_COLLINEAR && in_bbox(bx0, by0, ax0, ay0, bx1, by1)) begin
			return 1'b1;
		end
		if (t4 == TURN_COLLINEAR && in_bbox(bx0, by0, ax1, ay1, bx1, by1)) begin
			return 1'b1;
		end
		return 1'b0;
	endfunction

	class touch_scoreboard;
		bit touch_expected_q[$];
		int errors;
		int checked;
		int hits;

		function new();
			errors  = 0;
			checked = 0;
			hits    = 0;
		endfunction

		function void note_pair(seg_pair_t p);
			touch_expected_q.push_back(predict_touch(p));
		endfunction

		function void check_result(logic got);
			bit want;
			if (touch_expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual %b", $time, got);
				return;
			end
			want = touch_expected_q.pop_front();
			checked++;
			if (want) begin
				hits++;
			end
			if (got !== want) begin
				errors++;
				$display("%0t: segments_intersect mismatch, expected %b, actual %b",
					$time, want, got);
			end
		endfunction

		function int pending();
			return touch_expected_q.size();
		endfunction
	endclass

	touch_scoreboard sb;

	function automatic seg_pair_t mk_pair(int ax0, int ay0, int ax1, int ay1,
		int bx0, int by0, int bx1, int by1);
		seg_pair_t p;
		p.a_sx = ax0[COORD_W-1:0];
		p.a_sy = ay0[COORD_W-1:0];
		p.a_ex = ax1[COORD_W-1:0];
		p.a_ey = ay1[COORD_W-1:0];
		p.b_sx = bx0[COORD_W-1:0];
		p.b_sy = by0[COORD_W-1:0];
		p.b_ex = bx1[COORD_W-1:0];
		p.b_ey = by1[COORD_W-1:0];
		return p;
	endfunction

	function automatic seg_pair_t rand_pair();
		int c[8];
		int kind, base_x, base_y, dx, dy, span, pick;
		kind = $urandom_range(0, 9);
		for (int i = 0; i < 8; i++) begin
			c[i] = $urandom_range(0, 65535);
		end
		case (kind)
			2: begin
				for (int i = 0; i < 8; i++) begin
					case ($urandom_range(0, 5))
						0: c[i] = -32768;
						1: c[i] = 32767;
						2: c[i] = 0;
						3: c[i] = -1;
						4: c[i] = 1;
						default: c[i] = $urandom_range(0, 65535);
					endcase
				end
			end
			3, 4: begin
				for (int i = 0; i < 8; i++) begin
					c[i] = int'($urandom_range(0, 12)) - 6;
				end
			end
			5, 6, 8, 9: begin
				// points along one line, so collinear layouts come up often
				base_x = int'($urandom_range(0, 60000)) - 30000;
				base_y = int'($urandom_range(0, 60000)) - 30000;
				dx = int'($urandom_range(0, 80)) - 40;
				dy = int'($urandom_range(0, 80)) - 40;
				for (int i = 0; i < 4; i++) begin
					span = int'($urandom_range(0, 50)) - 25;
					c[2*i]   = base_x + span * dx;
					c[2*i+1] = base_y + span * dy;
				end
				if (kind == 8) begin
					c[2] = c[0];
					c[3] = c[1];
				end else if (kind == 9) begin
					// t junction: only segment b's end leaves the line
					c[6] = base_x + int'($urandom_range(0, 2000)) - 1000;
					c[7] = base_y + int'($urandom_range(0, 2000)) - 1000;
				end
			end
			7: begin
				if ($urandom_range(0, 1) == 1) begin
					for (int i = 0; i < 8; i++) begin
						c[i] = int'($urandom_range(0, 40)) - 20;
					end
				end
				pick = $urandom_range(0, 3);
				c[4 + 2*(pick % 2)]     = c[2*(pick / 2)];
				c[4 + 2*(pick % 2) + 1] = c[2*(pick / 2) + 1];
			end
			default: begin
			end
		endcase
		return mk_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
	endfunction

	task automatic send_pair(input seg_pair_t p, input int idle_pct);
		while ($urandom_range(0, 99) < idle_pct) begin
			pair_valid <= 1'b0;
			@(posedge clk);
		end
		seg_a_start_x <= p.a_sx;
		seg_a_start_y <= p.a_sy;
		seg_a_end_x   <= p.a_ex;
		seg_a_end_y   <= p.a_ey;
		seg_b_start_x <= p.b_sx;
		seg_b_start_y <= p.b_sy;
		seg_b_end_x   <= p.b_ex;
		seg_b_end_y   <= p.b_ey;
		pair_valid    <= 1'b1;
		@(posedge clk);
		while (pair_stall) begin
			@(posedge clk);
		end
		sb.note_pair(p);
		pairs_sent++;
	endtask

	task automatic wait_drained();
		pair_valid <= 1'b0;
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
	endtask

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results still outstanding", $time, sb.pending());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// result side: check transfers, random stall, long hold-off on request
	always @(posedge clk) begin : result_sink
		static logic hold_seen = 1'b0;
		static int   hold_left = 0;
		if (arst_n && result_valid && !result_stall) begin
			sb.check_result(segments_intersect);
		end
		if (hold_token !== hold_seen) begin
			hold_seen = hold_token;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left    = hold_left - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	initial begin
		int send_pct [4];
		int stall_pct[4];
		send_pct  = '{0, 54, 0, 11};
		stall_pct = '{0, 0, 54, 11};
		sb = new();
		arst_n         <= 1'b0;
		pair_valid     <= 1'b0;
		seg_a_start_x  <= '0;
		seg_a_start_y  <= '0;
		seg_a_end_x    <= '0;
		seg_a_end_y    <= '0;
		seg_b_start_x  <= '0;
		seg_b_start_y  <= '0;
		seg_b_end_x    <= '0;
		seg_b_end_y    <= '0;
		result_stall   <= 1'b0;
		recv_stall_pct <= 0;
		hold_token     <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corner cases
		send_pair(mk_pair(0, 0, 0, 0, 0, 0, 0, 0), 0);
		send_pair(mk_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768), 0);
		send_pair(mk_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767), 0);
		send_pair(mk_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768), 0);
		send_pair(mk_pair(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767), 0);
		send_pair(mk_pair(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767), 0);
		send_pair(mk_pair(-32768, 0, 0, 0, 0, 0, 32767, 0), 0);
		send_pair(mk_pair(-32768, 32767, 32767, -32768, 32767, -32768, -32768, 32767), 0);
		send_pair(mk_pair(0, 0, 10, 10, 5, 5, 20, 20), 0);
		send_pair(mk_pair(0, 0, 10, 10, 11, 11, 20, 20), 0);
		send_pair(mk_pair(0, 0, 10, 5, 10, 5, 20, -3), 0);
		send_pair(mk_pair(3, 3, 3, 3, 0, 0, 6, 6), 0);
		send_pair(mk_pair(3, 4, 3, 4, 0, 0, 6, 6), 0);
		send_pair(mk_pair(2, 2, 2, 2, 2, 2, 2, 2), 0);
		send_pair(mk_pair(1, 2, 1, 2, 2, 1, 2, 1), 0);
		send_pair(mk_pair(0, 0, 10, 0, 5, 0, 5, 7), 0);
		send_pair(mk_pair(0, 0, 10, 0, 5, 1, 5, 7), 0);
		send_pair(mk_pair(0, 10, 0, 0, 0, 5, 0, -5), 0);
		send_pair(mk_pair(0, 10, 0, 0, 0, -1, 0, -5), 0);
		send_pair(mk_pair(0, 0, 4, 4, 8, 8, 8, 0), 0);
		send_pair(mk_pair(16'h5555, 16'haaaa, 16'haaaa, 16'h5555, 16'h5555, 16'h5555,
			16'haaaa, 16'haaaa), 0);
		send_pair(mk_pair(-1, -1, 1, 1, -1, 1, 1, -1), 0);
		wait_drained();

		for (int ph = 0; ph < 4; ph++) begin
			recv_stall_pct <= stall_pct[ph];
			repeat (100) send_pair(rand_pair(), send_pct[ph]);
			wait_drained();
		end

		// back the pipeline up behind a held result register
		recv_stall_pct <= 0;
		hold_token     <= ~hold_token;
		repeat (30) send_pair(rand_pair(), 0);
		wait_drained();

		recv_stall_pct <= 30;
		repeat (20) send_pair(rand_pair(), 30);
		wait_drained();

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("ran %0d segment pairs: corner cases, collinear, degenerate and shared endpoint",
			pairs_sent);
		$display("layouts under four idle/stall mixes and a long hold-off; %0d of %0d touched",
			sb.hits, sb.checked);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches, %0d results never arrived", sb.errors, sb.pending());
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
